// ===== src/drr_pkg.sv =====
package drr_pkg;

	localparam int MAX_SCALE_DEF = 28;
	localparam int LIMB_W = 32;
	localparam int LIMBS = 3;
	localparam int MANT_W = LIMB_W * LIMBS;

	// Reciprocal of ten for a 36-bit dividend: ceil(2^39 / 10), shift 39.
	localparam logic [35:0] RECIP_TEN = 36'hCCCCCCCCD;
	localparam int RECIP_SHIFT = 39;

	localparam logic [1:0] CMD_BANKER = 2'd0;
	localparam logic [1:0] CMD_HALF_UP = 2'd1;
	localparam logic [1:0] CMD_FLOOR = 2'd2;

	typedef struct packed {
		logic [63:0] mantissa_low;
		logic [31:0] mantissa_high;
		logic negative;
		logic [4:0] scale;
		logic [4:0] shift_digits;
		logic [1:0] command;
	} in_item_t;

	typedef struct packed {
		logic [63:0] quotient_low;
		logic [31:0] quotient_high;
		logic negative_out;
		logic [4:0] scale_out;
		logic bad_shift;
	} out_item_t;

	// Item state as it moves down the divider pipeline.
	typedef struct packed {
		logic [MANT_W-1:0] limbs;
		logic [3:0] rem;
		logic [3:0] first;
		logic sticky;
		logic neg;
		logic [4:0] scale;
		logic [4:0] digits;
		logic [1:0] mode;
		logic bad;
	} work_t;

endpackage

// ===== src/drr_div_stage.sv =====
module drr_div_stage #(
	parameter int DIGIT = 0,
	parameter int LIMB = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  drr_pkg::work_t work_in,
	output logic valid_s1,
	output drr_pkg::work_t work_s1
);
	import drr_pkg::*;

	logic active;
	logic [3:0] rem_in;
	logic [35:0] cur;
	logic [71:0] prod;
	logic [31:0] quo;
	logic [35:0] back;
	logic [35:0] diff;
	work_t nxt;

	// The remainder chain restarts at the top limb of every digit.
	assign active = !work_in.bad && (32'(work_in.digits) > DIGIT);
	assign rem_in = (LIMB == LIMBS - 1) ? 4'd0 : work_in.rem;
	assign cur = {rem_in, work_in.limbs[LIMB*LIMB_W +: LIMB_W]};
	assign prod = 72'(cur) * 72'(RECIP_TEN);
	assign quo = prod[RECIP_SHIFT +: LIMB_W];
	assign back = ({4'd0, quo} << 3) + ({4'd0, quo} << 1);
	assign diff = cur - back;

	always_comb begin
		nxt = work_in;
		if (active) begin
			nxt.limbs[LIMB*LIMB_W +: LIMB_W] = quo;
			nxt.rem = diff[3:0];
			if (LIMB == 0) begin
				nxt.first = diff[3:0];
				nxt.sticky = work_in.sticky | (diff[3:0] != 4'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= nxt;
		end
	end

endmodule

// ===== src/drr_round.sv =====
module drr_round (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  drr_pkg::work_t work_in,
	output logic valid_s1,
	output drr_pkg::out_item_t item_s1
);
	import drr_pkg::*;

	logic inc;
	logic [MANT_W-1:0] sum;
	out_item_t nxt;

	always_comb begin
		inc = 1'b0;
		case (work_in.mode)
			CMD_BANKER: inc = (work_in.first > 4'd5) ||
				((work_in.first == 4'd5) && work_in.limbs[0]);
			CMD_HALF_UP: inc = (work_in.first >= 4'd5);
			CMD_FLOOR: inc = work_in.neg && work_in.sticky;
			default: inc = 1'b0;
		endcase
		if (work_in.bad || (work_in.digits == 5'd0)) begin
			inc = 1'b0;
		end
		sum = work_in.limbs + MANT_W'(inc);
		nxt.quotient_low = sum[63:0];
		nxt.quotient_high = sum[95:64];
		nxt.negative_out = work_in.neg;
		nxt.scale_out = work_in.bad ? work_in.scale : (work_in.scale - work_in.digits);
		nxt.bad_shift = work_in.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

// ===== src/decimal_rescale_round_top.sv =====
// Decimal rescale with rounding.
// An item on the input channel carries a 96-bit unsigned mantissa, its sign,
// its scale, a count of decimal digits to remove and a rounding mode. The
// result item carries the mantissa divided by ten to that count, rounded,
// the sign unchanged and the lowered scale. A count above the scale, or a
// scale above MAX_SCALE, sets bad_shift and passes the value through.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// The divider is a chain of 3 * MAX_SCALE register stages, one per 32-bit
// limb per decimal digit, each doing one reciprocal multiply by a tenth,
// followed by one rounding stage that is also the output register.
// Every item passes through all the stages, whatever the digit count, and
// one item is accepted in every cycle unless a stalled result holds the pipeline.
// Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised in the same cycle, so nothing is lost or repeated.
module decimal_rescale_round_top #(
	parameter int MAX_SCALE = drr_pkg::MAX_SCALE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  drr_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output drr_pkg::out_item_t out_data
);
	import drr_pkg::*;

	localparam int STAGES = LIMBS * MAX_SCALE;

	logic en;
	logic valid_w [STAGES+1];
	work_t work_w [STAGES+1];

	// The whole pipeline advances together unless a result is held at the output.
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_comb begin
		work_w[0].limbs = {in_data.mantissa_high, in_data.mantissa_low};
		work_w[0].rem = 4'd0;
		work_w[0].first = 4'd0;
		work_w[0].sticky = 1'b0;
		work_w[0].neg = in_data.negative;
		work_w[0].scale = in_data.scale;
		work_w[0].digits = in_data.shift_digits;
		work_w[0].mode = in_data.command;
		work_w[0].bad = (32'(in_data.scale) > 32'(MAX_SCALE)) ||
			(in_data.shift_digits > in_data.scale);
	end
	assign valid_w[0] = in_valid;

	// Each digit takes three stages, top limb first, carrying the remainder down.
	for (genvar j = 0; j < STAGES; j++) begin : g_div
		drr_div_stage #(
			.DIGIT(j / LIMBS),
			.LIMB(LIMBS - 1 - (j % LIMBS))
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(valid_w[j]),
			.work_in(work_w[j]),
			.valid_s1(valid_w[j+1]),
			.work_s1(work_w[j+1])
		);
	end

	drr_round u_round (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(valid_w[STAGES]),
		.work_in(work_w[STAGES]),
		.valid_s1(out_valid),
		.item_s1(out_data)
	);

endmodule

// ===== verif/decimal_rescale_round_top_test.sv =====
`timescale 1ns / 100ps

module decimal_rescale_round_top_test;
	import drr_pkg::*;

	localparam int LATENCY = 3 * MAX_SCALE_DEF + 1;
	localparam logic [1:0] CMD_TRUNC = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	in_item_t pending_items[$];
	out_item_t rescaled_q[$];
	int error_count;
	bit quiet_phase;
	bit hold_sender;
	bit feeding_done;

	decimal_rescale_round_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Works out the rounded, scaled-down value for one item. The mantissa is
	// divided by ten once per digit; the last remainder is the first digit
	// discarded, and any nonzero remainder marks the value as inexact.
	function automatic out_item_t rescale_predict(input in_item_t it);
		out_item_t res;
		logic [95:0] mant;
		logic [3:0] first_digit;
		bit inexact;
		mant = {it.mantissa_high, it.mantissa_low};
		first_digit = '0;
		inexact = 1'b0;
		res.negative_out = it.negative;
		res.bad_shift = 1'b0;
		res.scale_out = it.scale;
		if (it.scale > MAX_SCALE_DEF || it.shift_digits > it.scale) begin
			res.bad_shift = 1'b1;
		end else if (it.shift_digits != 0) begin
			for (int k = 0; k < it.shift_digits; k++) begin
				first_digit = 4'(mant % 96'd10);
				mant = mant / 96'd10;
				if (first_digit != 0)
					inexact = 1'b1;
			end
			case (it.command)
				CMD_BANKER: begin
					if (first_digit > 5 || (first_digit == 5 && mant[0]))
						mant = mant + 96'd1;
				end
				CMD_HALF_UP: begin
					if (first_digit >= 5)
						mant = mant + 96'd1;
				end
				CMD_FLOOR: begin
					if (it.negative && inexact)
						mant = mant + 96'd1;
				end
				default: begin
					// The spare code truncates.
				end
			endcase
			res.scale_out = it.scale - it.shift_digits;
		end
		res.quotient_low = mant[63:0];
		res.quotient_high = mant[95:64];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [95:0] got,
			input logic [95:0] want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		error_count++;
	endtask

	// Builds an item from a 96-bit mantissa and the small fields.
	function automatic in_item_t make_item(input logic [95:0] mant, input logic neg,
			input logic [4:0] scl, input logic [4:0] digs, input logic [1:0] cmd);
		in_item_t it;
		it.mantissa_low = mant[63:0];
		it.mantissa_high = mant[95:64];
		it.negative = neg;
		it.scale = scl;
		it.shift_digits = digs;
		it.command = cmd;
		return it;
	endfunction

	function automatic logic [95:0] random_mantissa();
		logic [95:0] m;
		m = {$urandom, $urandom, $urandom};
		// Half the values are made short so that small quotients and digit
		// boundaries get exercised as well as full-width ones.
		case ($urandom_range(0, 3))
			0: m = m >> $urandom_range(0, 95);
			1: m = m % 96'd1000000;
			default: ;
		endcase
		return m;
	endfunction

	// The driver offers the head of the queue and takes it away once accepted.
	// Valid is only computed once per edge, so it is never lowered and raised
	// within the same step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				rescaled_q.push_back(rescale_predict(in_data));
				void'(pending_items.pop_front());
			end
			if (in_valid && in_stall) begin
				// A stalled item stays exactly as it is.
			end else if (pending_items.size() > 0 && !hold_sender
					&& (quiet_phase || $urandom_range(0, 99) >= 27)) begin
				in_valid <= 1'b1;
				in_data <= pending_items[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The monitor stalls the output at random and checks every accepted item.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (rescaled_q.size() == 0) begin
					$display("unexpected result item");
					error_count++;
				end else begin
					want = rescaled_q.pop_front();
					if (out_data.quotient_low !== want.quotient_low)
						report_mismatch("quotient_low", 96'(out_data.quotient_low),
								96'(want.quotient_low));
					if (out_data.quotient_high !== want.quotient_high)
						report_mismatch("quotient_high", 96'(out_data.quotient_high),
								96'(want.quotient_high));
					if (out_data.negative_out !== want.negative_out)
						report_mismatch("negative_out", 96'(out_data.negative_out),
								96'(want.negative_out));
					if (out_data.scale_out !== want.scale_out)
						report_mismatch("scale_out", 96'(out_data.scale_out),
								96'(want.scale_out));
					if (out_data.bad_shift !== want.bad_shift)
						report_mismatch("bad_shift", 96'(out_data.bad_shift),
								96'(want.bad_shift));
				end
			end
			out_stall <= !quiet_phase && ($urandom_range(0, 99) < 27);
		end
	end

	initial begin
		logic [95:0] all_ones;
		logic [4:0] scl;
		all_ones = '1;
		error_count = 0;
		quiet_phase = 1'b0;
		hold_sender = 1'b0;
		feeding_done = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// Directed items: the extremes of the mantissa, every rounding mode,
		// a digit count above the scale, a zero count and a scale above the
		// limit, ties for banker's rounding on odd and even quotients.
		pending_items.push_back(make_item(all_ones, 1'b0, 5'd28, 5'd28, CMD_BANKER));
		pending_items.push_back(make_item(all_ones, 1'b1, 5'd28, 5'd1, CMD_HALF_UP));
		pending_items.push_back(make_item(all_ones, 1'b1, 5'd28, 5'd1, CMD_FLOOR));
		pending_items.push_back(make_item(all_ones, 1'b0, 5'd20, 5'd7, CMD_TRUNC));
		pending_items.push_back(make_item('0, 1'b1, 5'd0, 5'd0, CMD_FLOOR));
		pending_items.push_back(make_item(96'd15, 1'b0, 5'd3, 5'd1, CMD_BANKER));
		pending_items.push_back(make_item(96'd25, 1'b0, 5'd3, 5'd1, CMD_BANKER));
		pending_items.push_back(make_item(96'd25, 1'b1, 5'd3, 5'd1, CMD_HALF_UP));
		pending_items.push_back(make_item(96'd24, 1'b1, 5'd3, 5'd1, CMD_HALF_UP));
		pending_items.push_back(make_item(96'd2501, 1'b0, 5'd3, 5'd3, CMD_BANKER));
		pending_items.push_back(make_item(96'd1001, 1'b1, 5'd5, 5'd3, CMD_FLOOR));
		pending_items.push_back(make_item(96'd1001, 1'b0, 5'd5, 5'd3, CMD_FLOOR));
		pending_items.push_back(make_item(96'd1000, 1'b1, 5'd5, 5'd3, CMD_FLOOR));
		pending_items.push_back(make_item(96'd1234, 1'b0, 5'd2, 5'd3, CMD_BANKER));
		pending_items.push_back(make_item(96'd1234, 1'b1, 5'd31, 5'd3, CMD_HALF_UP));
		pending_items.push_back(make_item(96'd1234, 1'b0, 5'd29, 5'd29, CMD_BANKER));
		pending_items.push_back(make_item(96'd1234, 1'b0, 5'd4, 5'd31, CMD_FLOOR));
		pending_items.push_back(make_item(96'd99, 1'b0, 5'd0, 5'd0, CMD_TRUNC));
		pending_items.push_back(make_item(96'h8000_0000_0000_0000_0000_0000, 1'b1,
				5'd28, 5'd14, CMD_FLOOR));

		// Hold the sender until the pipeline has drained completely.
		wait (pending_items.size() == 0);
		hold_sender = 1'b1;
		wait (rescaled_q.size() == 0);
		repeat (LATENCY) @(posedge clk);
		hold_sender = 1'b0;

		for (int n = 0; n < 750; n++) begin
			in_item_t it;
			if (n == 200)
				quiet_phase = 1'b1;
			if (n == 350)
				quiet_phase = 1'b0;
			scl = $urandom_range(0, 28);
			it = make_item(random_mantissa(), 1'($urandom), scl,
					5'($urandom_range(0, scl)), 2'($urandom_range(0, 3)));
			// A few requests get random scale and count fields, many of them refused ones, including unused field values.
			if ($urandom_range(0, 19) == 0) begin
				it.scale = 5'($urandom);
				it.shift_digits = 5'($urandom);
			end
			pending_items.push_back(it);
			if (n == 200 || n == 350 || n == 749)
				wait (pending_items.size() == 0);
		end
		feeding_done = 1'b1;
	end

	initial begin
		wait (feeding_done);
		wait (pending_items.size() == 0 && !in_valid);
		wait (rescaled_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end
endmodule
